FILE: rtl/tld_pkg.sv
// Package for the terminal line discipline: store sizing, control byte codes
// and host function codes. No dependencies; used by tty_line_discipline_top.
package tld_pkg;

    localparam int LINE_DEPTH = 256;
    localparam int ADDR_W     = $clog2(LINE_DEPTH);
    localparam int CNT_W      = $clog2(LINE_DEPTH + 1);
    localparam int COUNT_OUT_W = 9;

    localparam logic [7:0] CHAR_BS    = 8'h08;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    localparam logic [2:0] REG_ADDR_ECHO = 3'h0;

    typedef enum logic [1:0] {
        FUNC_RECEIVE = 2'd0,
        FUNC_READ    = 2'd1,
        FUNC_WRITE   = 2'd2,
        FUNC_NONE    = 2'd3
    } func_t;

endpackage

FILE: rtl/tty_line_discipline_top.sv
// The first result of an accepted transaction is presented in the cycle after acceptance.
// Throughput: one input transaction per cycle when it yields one result and m_tready is high;
// an input that yields two or three results (echo of line end or backspace, written LF) holds
// the input side until the single result register drains them, one per cycle with m_tready.
// Reset: line state and handshakes clear, echo turns on; line store contents stay undefined.
// Top level of the terminal line discipline; depends on tld_pkg.
module tty_line_discipline_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [1:0]  s_tuser,   // [1:0] func
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] tx_byte, [15:8] read_byte, [16] line_ready,
                                   // [25:17] stored_count, [26] transfer_done, rest zero
    output logic [1:0]  m_tuser,   // [0] tx_valid, [1] read_valid
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0] line_store [tld_pkg::LINE_DEPTH];

    logic                        echo_reg;
    logic [tld_pkg::CNT_W-1:0]   count_reg, count_next;
    logic [tld_pkg::CNT_W-1:0]   rpos_reg, rpos_next;
    logic [7:0]                  prev_reg, prev_next;
    logic                        ready_reg, ready_next;

    logic                        pend_valid_reg;
    logic [1:0]                  pend_idx_reg;
    logic [1:0]                  pend_last_reg, pend_last_next;
    logic [2:0][7:0]             tx_reg, tx_next;
    logic                        txv_reg, txv_next;
    logic                        rdv_reg, rdv_next;
    logic                        done_reg, done_next;
    logic [7:0]                  rd_q_reg;

    logic                        accept;
    logic                        out_last;
    logic                        mem_we;
    logic [tld_pkg::ADDR_W-1:0]  mem_waddr;
    logic [7:0]                  mem_wdata;
    logic                        mem_re;
    tld_pkg::func_t              func;
    logic [7:0]                  tx_sel;

    assign func     = tld_pkg::func_t'(s_tuser);
    assign out_last = (pend_idx_reg == pend_last_reg);
    assign s_tready = !pend_valid_reg || (m_tready && out_last);
    assign accept   = s_tvalid && s_tready;

    assign pready = 1'b1;
    assign prdata = (paddr == tld_pkg::REG_ADDR_ECHO) ? {31'b0, echo_reg} : 32'b0;

    always_comb
    begin
        logic                      has_room;
        logic                      is_end;
        logic [7:0]                partner;
        logic [tld_pkg::CNT_W-1:0] rpos_inc;

        has_room = (count_reg < tld_pkg::CNT_W'(tld_pkg::LINE_DEPTH));
        is_end   = (s_tdata == tld_pkg::CHAR_CR) || (s_tdata == tld_pkg::CHAR_LF);
        partner  = (s_tdata == tld_pkg::CHAR_CR) ? tld_pkg::CHAR_LF : tld_pkg::CHAR_CR;
        rpos_inc = rpos_reg + 1'b1;

        count_next     = count_reg;
        rpos_next      = rpos_reg;
        prev_next      = prev_reg;
        ready_next     = ready_reg;
        pend_last_next = 2'd0;
        tx_next        = '0;
        txv_next       = 1'b0;
        rdv_next       = 1'b0;
        done_next      = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = count_reg[tld_pkg::ADDR_W-1:0];
        mem_wdata      = s_tdata;
        mem_re         = 1'b0;

        if (accept)
        begin
            case (func)
                tld_pkg::FUNC_RECEIVE:
                begin
                    if (echo_reg)
                    begin
                        if (s_tdata == tld_pkg::CHAR_BS)
                        begin
                            if (count_reg != '0)
                            begin
                                tx_next        = {tld_pkg::CHAR_BS, tld_pkg::CHAR_SPACE,
                                                  tld_pkg::CHAR_BS};
                                txv_next       = 1'b1;
                                pend_last_next = 2'd2;
                            end
                        end
                        else if (is_end)
                        begin
                            tx_next[0]     = tld_pkg::CHAR_CR;
                            tx_next[1]     = tld_pkg::CHAR_LF;
                            txv_next       = 1'b1;
                            pend_last_next = 2'd1;
                        end
                        else if (has_room)
                        begin
                            tx_next[0] = s_tdata;
                            txv_next   = 1'b1;
                        end
                    end

                    if (s_tdata == tld_pkg::CHAR_BS)
                    begin
                        if (count_reg != '0)
                        begin
                            count_next = count_reg - 1'b1;
                        end
                    end
                    else if (is_end)
                    begin
                        if (prev_reg != partner)
                        begin
                            ready_next = 1'b1;
                            if (has_room)
                            begin
                                mem_we     = 1'b1;
                                mem_wdata  = tld_pkg::CHAR_LF;
                                count_next = count_reg + 1'b1;
                            end
                        end
                    end
                    else if (has_room)
                    begin
                        mem_we     = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    prev_next = s_tdata;
                end
                tld_pkg::FUNC_READ:
                begin
                    done_next = 1'b1;
                    if (ready_reg)
                    begin
                        if (rpos_reg >= count_reg)
                        begin
                            ready_next = 1'b0;
                            count_next = '0;
                            rpos_next  = '0;
                        end
                        else
                        begin
                            mem_re   = 1'b1;
                            rdv_next = 1'b1;
                            if (rpos_inc == count_reg)
                            begin
                                ready_next = 1'b0;
                                count_next = '0;
                                rpos_next  = '0;
                            end
                            else
                            begin
                                rpos_next = rpos_inc;
                                done_next = s_tlast;
                            end
                        end
                    end
                end
                tld_pkg::FUNC_WRITE:
                begin
                    txv_next  = 1'b1;
                    done_next = s_tlast;
                    if (s_tdata == tld_pkg::CHAR_LF)
                    begin
                        tx_next[0]     = tld_pkg::CHAR_CR;
                        tx_next[1]     = tld_pkg::CHAR_LF;
                        pend_last_next = 2'd1;
                    end
                    else
                    begin
                        tx_next[0] = s_tdata;
                    end
                end
                default:
                begin
                    pend_last_next = 2'd0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            line_store[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_q_reg <= line_store[rpos_reg[tld_pkg::ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            echo_reg       <= 1'b1;
            count_reg      <= '0;
            rpos_reg       <= '0;
            prev_reg       <= '0;
            ready_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            pend_idx_reg   <= 2'd0;
            pend_last_reg  <= 2'd0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && (paddr[2] == tld_pkg::REG_ADDR_ECHO[2]))
            begin
                echo_reg <= pwdata[0];
            end
            count_reg <= count_next;
            rpos_reg  <= rpos_next;
            prev_reg  <= prev_next;
            ready_reg <= ready_next;
            if (accept)
            begin
                pend_valid_reg <= 1'b1;
                pend_idx_reg   <= 2'd0;
                pend_last_reg  <= pend_last_next;
            end
            else if (pend_valid_reg && m_tready)
            begin
                if (out_last)
                begin
                    pend_valid_reg <= 1'b0;
                end
                else
                begin
                    pend_idx_reg <= pend_idx_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tx_reg   <= tx_next;
            txv_reg  <= txv_next;
            rdv_reg  <= rdv_next;
            done_reg <= done_next;
        end
    end

    always_comb
    begin
        case (pend_idx_reg)
            2'd0:    tx_sel = tx_reg[0];
            2'd1:    tx_sel = tx_reg[1];
            2'd2:    tx_sel = tx_reg[2];
            default: tx_sel = 8'h00;
        endcase
    end

    assign m_tvalid = pend_valid_reg;
    assign m_tlast  = out_last;
    assign m_tuser  = {rdv_reg, txv_reg};
    assign m_tdata  = {5'b0,
                       done_reg && out_last,
                       tld_pkg::COUNT_OUT_W'(count_reg),
                       ready_reg,
                       rdv_reg ? rd_q_reg : 8'h00,
                       tx_sel};

endmodule
